// File: rtl/midi_track_event_parser_unit_macros.svh
// assertion macros for the midi track event parser
`ifndef MIDI_TRACK_EVENT_PARSER_UNIT_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define MTEP_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
// next-cycle implication
`define MTEP_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

// File: rtl/mtep_pkg.sv
// shared types, constants and functions of the midi track event parser
package mtep_pkg;

  typedef enum logic [3:0] {
    PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_META_TYPE, PH_META_LEN, PH_SKIP,
    PH_TEMPO, PH_END_LEN, PH_ENDED, PH_SYS_LEN, PH_SYS_DATA
  } phase_t;

  typedef enum logic [3:0] {
    EV_NOTEOFF = 4'd0, EV_NOTEON = 4'd1, EV_POLY = 4'd2, EV_CTRL = 4'd3, EV_PROG = 4'd4,
    EV_CHPRESS = 4'd5, EV_BEND = 4'd6, EV_TEMPO = 4'd7, EV_DELTA = 4'd8, EV_END = 4'd9
  } kind_t;

  typedef enum logic [2:0] {
    SQ_IDLE, SQ_DIV, SQ_MUL, SQ_SCALE, SQ_DONE
  } seq_t;

  localparam logic [7:0] META_END = 8'h2F;
  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [7:0] META_SMPTE = 8'h54;
  localparam logic [7:0] META_TIMESIG = 8'h58;
  localparam logic [7:0] META_KEYSIG = 8'h59;
  localparam logic [7:0] SYSEX_END = 8'hF7;
  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] META_START = 8'hFF;
  localparam logic [25:0] USEC_PER_MIN = 26'd60000000;
  localparam int DivSteps = 26;

  localparam logic [0:0] REG_DIVISION = 1'b0;
  localparam logic [0:0] REG_TEMPO_NOLEN = 1'b1;

  // result transaction
  typedef struct packed {
    logic [3:0] kind;
    logic [3:0] channel;
    logic [6:0] first_data;
    logic [6:0] second_data;
    logic [29:0] value;
  } result_t;

  // request to the arithmetic unit
  typedef struct packed {
    logic start;
    logic is_tempo;
    logic [27:0] operand;
    logic [2:0] remainder;
  } arith_req_t;

  // answer of the arithmetic unit
  typedef struct packed {
    logic done;
    logic [29:0] value;
    logic [2:0] remainder;
  } arith_rsp_t;

  // data bytes following a status nibble
  function automatic logic [1:0] data_count(input logic [3:0] hi);
    case (hi)
      4'h8, 4'h9, 4'hA, 4'hB, 4'hE: data_count = 2'd2;
      4'hC, 4'hD: data_count = 2'd1;
      default: data_count = 2'd0;
    endcase
  endfunction

endpackage

// File: rtl/mtep_arith.sv
// shared shift-subtract unit: tempo division and delta scaling
module mtep_arith (
  input  logic clk,
  input  logic rst,
  input  logic [15:0] division,
  input  mtep_pkg::arith_req_t req,
  output mtep_pkg::arith_rsp_t rsp
);

  mtep_pkg::seq_t state, state_next;
  logic [4:0] count;
  logic [25:0] quo;
  logic [24:0] rem;
  logic [23:0] divisor;
  logic [33:0] acc;
  logic [2:0] r_out;
  logic is_tempo;
  logic [24:0] trial;
  logic [24:0] shifted;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mtep_pkg::SQ_IDLE: if (req.start) begin
        if (req.is_tempo && req.operand[23:0] != 24'd0) state_next = mtep_pkg::SQ_DIV;
        else state_next = mtep_pkg::SQ_SCALE;
      end
      mtep_pkg::SQ_DIV: if (count == 5'(mtep_pkg::DivSteps - 1)) state_next = mtep_pkg::SQ_MUL;
      mtep_pkg::SQ_MUL: state_next = mtep_pkg::SQ_SCALE;
      mtep_pkg::SQ_SCALE: state_next = mtep_pkg::SQ_DONE;
      mtep_pkg::SQ_DONE: state_next = mtep_pkg::SQ_IDLE;
      default: state_next = mtep_pkg::SQ_IDLE;
    endcase
  end

  assign shifted = {rem[23:0], quo[25]};
  assign trial = shifted - {1'b0, divisor};

  // outputs
  always_comb begin
    rsp.done = (state == mtep_pkg::SQ_DONE);
    rsp.value = acc[29:0];
    rsp.remainder = r_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtep_pkg::SQ_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state != state_next) count <= '0;
      else count <= count + 5'd1;
    end
    case (state)
      mtep_pkg::SQ_IDLE: begin
        is_tempo <= req.is_tempo;
        rem <= '0;
        r_out <= req.remainder;
        if (req.is_tempo) begin
          quo <= mtep_pkg::USEC_PER_MIN;
          divisor <= req.operand[23:0];
          acc <= 34'd255;
        end else begin
          acc <= {6'd0, req.operand};
        end
      end
      // restoring division, one quotient bit a cycle
      mtep_pkg::SQ_DIV: begin
        if (!trial[24]) begin
          rem <= trial;
          quo <= {quo[24:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[24:0], 1'b0};
        end
      end
      // q*100/115 = q*20/23; at q >= 294 the result is capped anyway,
      // below that a reciprocal multiply by 20*5699/2^17 is exact
      mtep_pkg::SQ_MUL: begin
        if (quo >= 26'd294) acc <= 34'd255;
        else acc <= 34'((26'(quo[8:0]) * 26'd113980) >> 17);
      end
      mtep_pkg::SQ_SCALE: begin
        if (is_tempo) begin
          if (divisor == 24'd0) acc <= 34'd255;
          else if (acc > 34'd255) acc <= 34'd255;
          if (division == 16'd24 || division == 16'd60) acc <= 34'((divisor == 24'd0 ||
            acc > 34'd255) ? 34'd255 : acc) >> 1;
          else if (division == 16'd30) acc <= 34'((divisor == 24'd0 ||
            acc > 34'd255) ? 34'd255 : acc) >> 2;
        end else if (acc != 34'd0) begin
          case (division)
            16'd48: begin
              acc <= (acc * 34'd10 + 34'(r_out)) >> 2;
              r_out <= {1'b0, 2'(acc * 34'd10 + 34'(r_out))};
            end
            16'd96: begin
              acc <= (acc * 34'd5 + 34'(r_out)) >> 2;
              r_out <= {1'b0, 2'(acc * 34'd5 + 34'(r_out))};
            end
            16'd192, 16'd240: begin
              acc <= (acc + 34'(r_out)) >> 1;
              r_out <= {2'b0, 1'(acc + 34'(r_out))};
            end
            // divide by 3 through the reciprocal ceil(2^29/3), exact for 28 bits
            16'd288, 16'd360: acc <= 34'((56'(acc[27:0]) * 56'd178956971) >> 29);
            16'd384, 16'd480: begin
              acc <= (acc + 34'(r_out)) >> 2;
              r_out <= {1'b0, 2'(acc + 34'(r_out))};
            end
            16'd768, 16'd960: begin
              acc <= (acc + 34'(r_out)) >> 3;
              r_out <= 3'(acc + 34'(r_out));
            end
            default: acc <= acc;
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/midi_track_event_parser_unit.sv
// top level of the midi track event parser
// Usage: one track byte per input transaction on data_byte, with
// track_start high on the first byte of a track. A result transaction
// carries one decoded event: channel message, scaled delta, tempo tick
// increment or end of track. Configuration (ticks_division at index 0,
// tempo_without_length at index 1) is written through cfg_we/cfg_index/cfg_data;
// the user must write it only while the block is idle; the block does not enforce it.
// Path: a channel event or end result is valid the cycle after its byte
// is taken; a delta result passes the request register and the arithmetic
// unit's scale and done states; a tempo result first passes the 26 divider
// steps and the constant scale with its cap, which a zero tempo skips.
// Throughput: one byte at a time; a byte with no result frees the input the
// next cycle, otherwise the input is stalled until the result is taken.
// Reset clears the parse state and configuration; the output is empty.
// When the receiver stalls, the result holds steady and no new byte is taken.
module midi_track_event_parser_unit (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] data_byte,
  input  logic track_start,
  output logic out_valid,
  input  logic out_stall,
  output logic [3:0] event_kind,
  output logic [3:0] channel,
  output logic [6:0] first_data,
  output logic [6:0] second_data,
  output logic [29:0] event_value,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [15:0] cfg_data
);
`include "midi_track_event_parser_unit_macros.svh"

  logic [15:0] division;
  logic tempo_nolen;
  mtep_pkg::phase_t phase;
  logic [7:0] running_status;
  logic [7:0] held_data;
  logic [27:0] bytes_left;
  logic [27:0] len_acc;
  logic [23:0] tempo_acc;
  logic [2:0] tick_rem;
  logic busy;
  logic [3:0] pend_kind;
  mtep_pkg::arith_req_t req;
  mtep_pkg::arith_rsp_t rsp;
  logic in_take;

  assign in_stall = busy || out_valid;
  assign in_take = in_valid && !in_stall;

  mtep_arith u_arith (
    .clk(clk), .rst(rst), .division(division), .req(req), .rsp(rsp)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      division <= '0;
      tempo_nolen <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == mtep_pkg::REG_DIVISION) division <= cfg_data;
      else tempo_nolen <= cfg_data[0];
    end
  end

  // byte parser
  always_ff @(posedge clk) begin
    logic [7:0] b;
    logic [27:0] acc_v;
    mtep_pkg::phase_t ph;
    logic [7:0] rs;
    logic [7:0] hd;
    logic [27:0] bl;
    logic [27:0] la;
    logic [23:0] ta;
    logic [2:0] tr;
    logic [1:0] n;
    logic res_valid;
    mtep_pkg::result_t res;
    mtep_pkg::arith_req_t rq;
    b = data_byte;
    acc_v = '0;
    ph = phase;
    rs = running_status;
    hd = held_data;
    bl = bytes_left;
    la = len_acc;
    ta = tempo_acc;
    tr = tick_rem;
    n = '0;
    res_valid = 1'b0;
    res = '0;
    rq = req;
    rq.start = 1'b0;
    if (rst) begin
      phase <= mtep_pkg::PH_DELTA;
      running_status <= '0;
      held_data <= '0;
      bytes_left <= '0;
      len_acc <= '0;
      tempo_acc <= '0;
      tick_rem <= '0;
      busy <= 1'b0;
      out_valid <= 1'b0;
      req <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (busy && rsp.done) begin
        busy <= 1'b0;
        out_valid <= 1'b1;
        event_kind <= pend_kind;
        channel <= '0;
        first_data <= '0;
        second_data <= '0;
        event_value <= rsp.value;
        if (pend_kind == mtep_pkg::EV_DELTA) tick_rem <= rsp.remainder;
      end
      if (in_take) begin
        if (track_start) begin
          ph = mtep_pkg::PH_DELTA;
          rs = '0;
          hd = '0;
          bl = '0;
          la = '0;
          ta = '0;
          tr = '0;
        end
        acc_v = {la[20:0], b[6:0]};
        case (ph)
          mtep_pkg::PH_DELTA: begin
            la = acc_v;
            if (!b[7]) begin
              la = '0;
              ph = mtep_pkg::PH_STATUS;
              busy <= 1'b1;
              pend_kind <= mtep_pkg::EV_DELTA;
              rq = '{start: 1'b1, is_tempo: 1'b0, operand: acc_v, remainder: tr};
            end
          end
          mtep_pkg::PH_STATUS: begin
            if (!b[7]) begin
              n = mtep_pkg::data_count(rs[7:4]);
              ph = mtep_pkg::PH_DELTA;
              if (n == 2'd1) begin
                res_valid = 1'b1;
                res.kind = (rs[7:4] == 4'hC) ? mtep_pkg::EV_PROG : mtep_pkg::EV_CHPRESS;
                res.channel = rs[3:0];
                res.first_data = b[6:0];
              end else if (n == 2'd2) begin
                hd = b;
                ph = mtep_pkg::PH_DATA2;
              end
            end else begin
              if (b != mtep_pkg::META_START) rs = b;
              if (mtep_pkg::data_count(b[7:4]) != 2'd0) ph = mtep_pkg::PH_DATA1;
              else if (b == mtep_pkg::SYSEX_START) ph = mtep_pkg::PH_SYS_LEN;
              else if (b == mtep_pkg::META_START) ph = mtep_pkg::PH_META_TYPE;
              else ph = mtep_pkg::PH_DELTA;
            end
          end
          mtep_pkg::PH_DATA1: begin
            if (mtep_pkg::data_count(rs[7:4]) == 2'd2) begin
              hd = b;
              ph = mtep_pkg::PH_DATA2;
            end else begin
              ph = mtep_pkg::PH_DELTA;
              res_valid = 1'b1;
              res.kind = (rs[7:4] == 4'hC) ? mtep_pkg::EV_PROG : mtep_pkg::EV_CHPRESS;
              res.channel = rs[3:0];
              res.first_data = b[6:0];
            end
          end
          mtep_pkg::PH_DATA2: begin
            ph = mtep_pkg::PH_DELTA;
            res_valid = 1'b1;
            res.channel = rs[3:0];
            res.first_data = hd[6:0];
            res.second_data = b[6:0];
            case (rs[7:4])
              4'h8: res.kind = mtep_pkg::EV_NOTEOFF;
              4'h9: res.kind = (b[6:0] != 7'd0) ? mtep_pkg::EV_NOTEON : mtep_pkg::EV_NOTEOFF;
              4'hA: res.kind = mtep_pkg::EV_POLY;
              4'hB: res.kind = mtep_pkg::EV_CTRL;
              default: res.kind = mtep_pkg::EV_BEND;
            endcase
          end
          mtep_pkg::PH_META_TYPE: begin
            case (b)
              mtep_pkg::META_END: ph = mtep_pkg::PH_END_LEN;
              mtep_pkg::META_TEMPO: begin
                ta = '0;
                bl = tempo_nolen ? 28'd3 : 28'd4;
                ph = mtep_pkg::PH_TEMPO;
              end
              mtep_pkg::META_SMPTE: begin bl = 28'd6; ph = mtep_pkg::PH_SKIP; end
              mtep_pkg::META_TIMESIG: begin bl = 28'd5; ph = mtep_pkg::PH_SKIP; end
              mtep_pkg::META_KEYSIG: begin bl = 28'd3; ph = mtep_pkg::PH_SKIP; end
              default: begin la = '0; ph = mtep_pkg::PH_META_LEN; end
            endcase
          end
          mtep_pkg::PH_META_LEN: begin
            la = acc_v;
            if (!b[7]) begin
              la = '0;
              bl = acc_v;
              ph = (acc_v == 28'd0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
            end
          end
          mtep_pkg::PH_SKIP: begin
            if (bl <= 28'd1) begin
              bl = '0;
              ph = mtep_pkg::PH_DELTA;
            end else bl = bl - 28'd1;
          end
          mtep_pkg::PH_TEMPO: begin
            ta = {ta[15:0], b};
            if (bl <= 28'd1) begin
              bl = '0;
              ph = mtep_pkg::PH_DELTA;
              busy <= 1'b1;
              pend_kind <= mtep_pkg::EV_TEMPO;
              rq = '{start: 1'b1, is_tempo: 1'b1, operand: {4'd0, ta}, remainder: 3'd0};
            end else bl = bl - 28'd1;
          end
          mtep_pkg::PH_END_LEN: begin
            ph = mtep_pkg::PH_ENDED;
            res_valid = 1'b1;
            res.kind = mtep_pkg::EV_END;
          end
          mtep_pkg::PH_ENDED: ph = mtep_pkg::PH_ENDED;
          mtep_pkg::PH_SYS_LEN: begin
            la = acc_v;
            if (!b[7]) begin
              la = '0;
              bl = (acc_v == 28'd0) ? 28'd1 : acc_v;
              ph = mtep_pkg::PH_SYS_DATA;
            end
          end
          mtep_pkg::PH_SYS_DATA: begin
            if (b == mtep_pkg::SYSEX_END || bl <= 28'd1) begin
              bl = '0;
              ph = mtep_pkg::PH_DELTA;
            end else bl = bl - 28'd1;
          end
          default: ph = mtep_pkg::PH_DELTA;
        endcase
        phase <= ph;
        running_status <= rs;
        held_data <= hd;
        bytes_left <= bl;
        len_acc <= la;
        tempo_acc <= ta;
        tick_rem <= tr;
        if (res_valid) begin
          out_valid <= 1'b1;
          event_kind <= res.kind;
          channel <= res.channel;
          first_data <= res.first_data;
          second_data <= res.second_data;
          event_value <= '0;
        end
      end
      req <= rq;
    end
  end

  `MTEP_ASSERT_IMP(a_no_take_busy, busy, in_stall)
  `MTEP_ASSERT_NXT(a_start_busy, in_take && !track_start && phase == mtep_pkg::PH_TEMPO
    && bytes_left == 28'd1, busy)
  `MTEP_ASSERT_IMP(a_done_busy, rsp.done, busy)

endmodule
